/* sv/cdjd_pkg.sv */
// cdjd_pkg: constants and the month table for the calendar date to julian day converter
// no dependencies; used by calendar_date_to_julian_day
package cdjd_pkg;

  localparam int unsigned SecPerDay  = 86400;
  localparam int unsigned HalfDaySec = 43200;
  localparam int          CutYear    = 1582;
  localparam int unsigned CutMonth   = 10;
  localparam int unsigned CutDay     = 15;
  localparam int          YearOffset = 4716;
  localparam int          DayBias    = 1525;
  localparam int          CentBias   = 16400;
  localparam int          CentBase   = 164;
  localparam int unsigned CentRecip  = 5243;
  localparam int unsigned CentShift  = 19;

  // floor(30.6001 * (m + 1)) for shifted month m in 3..15
  function automatic logic [8:0] month_term(input logic [3:0] m);
    logic [8:0] r;
    unique case (m)
      4'd3:    r = 9'd122;
      4'd4:    r = 9'd153;
      4'd5:    r = 9'd183;
      4'd6:    r = 9'd214;
      4'd7:    r = 9'd244;
      4'd8:    r = 9'd275;
      4'd9:    r = 9'd306;
      4'd10:   r = 9'd336;
      4'd11:   r = 9'd367;
      4'd12:   r = 9'd397;
      4'd13:   r = 9'd428;
      4'd14:   r = 9'd459;
      4'd15:   r = 9'd489;
      default: r = 9'd0;
    endcase
    return r;
  endfunction

endpackage

/* sv/calendar_date_to_julian_day.sv */
// calendar_date_to_julian_day: four-stage pipeline, calendar date and time to julian day
// depends on cdjd_pkg
//
//   channel | direction | handshake                 | word
//   in      | sink      | in_valid_i / in_stall_o   | year, month, day, hour, minute, second
//   out     | source    | out_valid_o / out_stall_i | jd_days, jd_seconds
//
// four register stages, one word per cycle while out_stall_i is low
// stage 1 adjusts year and month, stage 2 holds the two constant multiplies,
// stage 3 sums the day count, stage 4 carries seconds into days and saturates
// each stage holds its word until the next one frees, bubbles are squeezed out
// reset clears only the stage valid bits
module calendar_date_to_julian_day (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic signed [14:0] year_i,
  input  logic        [3:0]  month_i,
  input  logic        [4:0]  day_i,
  input  logic        [4:0]  hour_i,
  input  logic        [5:0]  minute_i,
  input  logic        [5:0]  second_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic        [22:0] jd_days_o,
  output logic        [16:0] jd_seconds_o
);

  logic v1_q, v2_q, v3_q, v4_q;
  logic en1, en2, en3, en4;

  assign en4 = !v4_q || !out_stall_i;
  assign en3 = !v3_q || en4;
  assign en2 = !v2_q || en3;
  assign en1 = !v1_q || en2;
  assign in_stall_o = !en1;

  // stage 1
  logic signed [15:0] y1_d, y1_q;
  logic        [3:0]  m1_d, m1_q;
  logic        [4:0]  day1_q;
  logic               pre1_d, pre1_q;
  logic        [16:0] tod1_d, tod1_q;

  always_comb begin
    y1_d = {year_i[14], year_i};
    if (year_i < 15'sd0) begin
      y1_d = y1_d + 16'sd1;
    end
    m1_d = month_i;
    if (month_i <= 4'd2) begin
      y1_d = y1_d - 16'sd1;
      m1_d = month_i + 4'd12;
    end
    priority if (year_i != 15'(cdjd_pkg::CutYear)) begin
      pre1_d = year_i < 15'(cdjd_pkg::CutYear);
    end else if (month_i != 4'(cdjd_pkg::CutMonth)) begin
      pre1_d = month_i < 4'(cdjd_pkg::CutMonth);
    end else begin
      pre1_d = day_i < 5'(cdjd_pkg::CutDay);
    end
    tod1_d = 17'(hour_i * 17'd3600) + 17'(minute_i * 17'd60) + 17'(second_i);
  end

  // stage 2
  logic signed [15:0] t2;
  logic        [15:0] u2;
  logic        [28:0] cprod2;
  logic signed [26:0] prod2_d, prod2_q;
  logic        [9:0]  cent2_q;
  logic        [8:0]  mt2_q;
  logic        [4:0]  day2_q;
  logic               pre2_q;
  logic        [16:0] tod2_q;

  always_comb begin
    t2      = y1_q + 16'(cdjd_pkg::YearOffset);
    u2      = 16'(y1_q + 16'(cdjd_pkg::CentBias));
    cprod2  = 29'(u2) * 29'(cdjd_pkg::CentRecip);
    prod2_d = $signed({{11{t2[15]}}, t2}) * 27'sd1461;
  end

  // stage 3
  logic signed [10:0] a3, b3;
  logic signed [24:0] days3_d, days3_q;
  logic        [17:0] secs3_q;

  always_comb begin
    a3 = $signed({1'b0, cent2_q}) - 11'(cdjd_pkg::CentBase);
    b3 = pre2_q ? 11'sd0 : (11'sd2 - a3 + (a3 >>> 2));
    days3_d = prod2_q[26:2]
            + $signed({16'b0, mt2_q})
            + $signed({20'b0, day2_q})
            + $signed({{14{b3[10]}}, b3})
            - 25'(cdjd_pkg::DayBias);
  end

  // stage 4
  logic signed [24:0] days4;
  logic        [17:0] secs4;
  logic        [22:0] jd_days_d, jd_days_q;
  logic        [16:0] jd_seconds_d, jd_seconds_q;

  always_comb begin
    days4 = days3_q;
    secs4 = secs3_q;
    if (secs3_q >= 18'(cdjd_pkg::SecPerDay)) begin
      secs4 = secs3_q - 18'(cdjd_pkg::SecPerDay);
      days4 = days3_q + 25'sd1;
    end
    if (days4 < 25'sd0) begin
      jd_days_d    = '0;
      jd_seconds_d = '0;
    end else begin
      jd_days_d    = days4[22:0];
      jd_seconds_d = secs4[16:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
    end else begin
      if (en1) v1_q <= in_valid_i;
      if (en2) v2_q <= v1_q;
      if (en3) v3_q <= v2_q;
      if (en4) v4_q <= v3_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en1) begin
      y1_q   <= y1_d;
      m1_q   <= m1_d;
      day1_q <= day_i;
      pre1_q <= pre1_d;
      tod1_q <= tod1_d;
    end
    if (en2) begin
      prod2_q <= prod2_d;
      cent2_q <= cprod2[28:19];
      mt2_q   <= cdjd_pkg::month_term(m1_q);
      day2_q  <= day1_q;
      pre2_q  <= pre1_q;
      tod2_q  <= tod1_q;
    end
    if (en3) begin
      days3_q <= days3_d;
      secs3_q <= 18'(tod2_q) + 18'(cdjd_pkg::HalfDaySec);
    end
    if (en4) begin
      jd_days_q    <= jd_days_d;
      jd_seconds_q <= jd_seconds_d;
    end
  end

  assign out_valid_o  = v4_q;
  assign jd_days_o    = jd_days_q;
  assign jd_seconds_o = jd_seconds_q;

  // input stalls only when every stage is full and the output is held
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> (v1_q && v2_q && v3_q && v4_q && out_stall_i))
    else $error("input stalled with a free stage");

  // seconds stay within one day
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (jd_seconds_o < 17'(cdjd_pkg::SecPerDay)))
    else $error("jd_seconds out of range");

  // a word in stage 3 moves to the output when the output is free
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (v3_q && en4) |=> out_valid_o)
    else $error("word lost between stage 3 and output");

  // a held output word keeps its stage 3 successor in place
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (v4_q && out_stall_i && v3_q) |=> (v3_q && $stable(days3_q)))
    else $error("stage 3 word changed while blocked");

endmodule
